@@ hw/rtl/mtnp_pkg.sv @@
`timescale 1ns / 1ps
package mtnp_pkg;

  localparam int DEFAULT_STACK_DEPTH = 4;
  localparam int NUM_KEYS            = 2048;
  localparam int KEY_W               = 11;

  // item actions
  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_BEGIN = 2'd1;
  localparam logic [1:0] ACT_DRAIN = 2'd2;

  // result kinds
  localparam logic [2:0] K_NOTE    = 3'd0;
  localparam logic [2:0] K_TEMPO   = 3'd1;
  localparam logic [2:0] K_SIG     = 3'd2;
  localparam logic [2:0] K_END     = 3'd3;
  localparam logic [2:0] K_VLERR   = 3'd4;
  localparam logic [2:0] K_DRAINED = 3'd5;

  // parser phases
  localparam logic [3:0] PH_DELTA     = 4'd0;
  localparam logic [3:0] PH_STATUS    = 4'd1;
  localparam logic [3:0] PH_DATA1     = 4'd2;
  localparam logic [3:0] PH_DATA2     = 4'd3;
  localparam logic [3:0] PH_META_TYPE = 4'd4;
  localparam logic [3:0] PH_META_LEN  = 4'd5;
  localparam logic [3:0] PH_META_DATA = 4'd6;
  localparam logic [3:0] PH_SYSEX_LEN = 4'd7;
  localparam logic [3:0] PH_SKIP      = 4'd8;
  localparam logic [3:0] PH_DONE      = 4'd9;

  // status and meta bytes
  localparam logic [7:0] META_EOT   = 8'h2F;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_SIG   = 8'h58;
  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [7:0] ST_SYSEX   = 8'hF0;
  localparam logic [7:0] ST_ESCAPE  = 8'hF7;

  // note table operations
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;

  // depth write values
  localparam logic [1:0] DV_ZERO = 2'd0;
  localparam logic [1:0] DV_INC  = 2'd1;
  localparam logic [1:0] DV_DEC  = 2'd2;

  // result sources
  localparam logic [1:0] ES_NOTE    = 2'd0;
  localparam logic [1:0] ES_SLOT_A  = 2'd1;
  localparam logic [1:0] ES_SLOT_B  = 2'd2;
  localparam logic [1:0] ES_DRAINED = 2'd3;

  typedef struct packed {
    logic       take;
    logic       commit;
    logic       clr_regs;
    logic       wk_drain;
    logic       wk_inc;
    logic       dep_rd;
    logic       dep_wr;
    logic [1:0] dep_val;
    logic       st_rd;
    logic       st_wr;
    logic       st_shift;
    logic       wi_top;
    logic       wi_dr;
    logic       wi_one;
    logic       wi_inc;
    logic       ovf_set;
    logic       dsub_zero;
    logic       drain_pick;
    logic       drain_reset;
    logic       emit;
    logic [1:0] emit_src;
  } mtnp_cmd_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] act;
    logic       ph_done;
    logic [1:0] op;
    logic       dr_zero;
    logic       dr_full;
    logic       wk_last;
    logic       wi_end;
    logic       sa_v;
    logic       sb_v;
    logic       out_free;
  } mtnp_sts_t;

endpackage

@@ hw/rtl/mtnp_if.sv @@
`timescale 1ns / 1ps
interface mtnp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, action, data_byte, last_byte, input ready);
  modport sink (input valid, action, data_byte, last_byte, output ready);
endinterface

interface mtnp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] onset_tick;
  logic [31:0] release_tick;
  logic [6:0]  pitch;
  logic [4:0]  channel;
  logic [23:0] usec_per_quarter;
  logic [7:0]  numerator;
  logic [7:0]  denominator_log2;
  logic        stack_overflow;
  modport source (output valid, kind, onset_tick, release_tick, pitch, channel,
                  usec_per_quarter, numerator, denominator_log2, stack_overflow,
                  input ready);
  modport sink (input valid, kind, onset_tick, release_tick, pitch, channel,
                usec_per_quarter, numerator, denominator_log2, stack_overflow,
                output ready);
endinterface

@@ hw/rtl/midi_track_note_pairing_parser.sv @@
`timescale 1ns / 1ps
// one request in flight: a track byte is parsed, then a note-on pushes its start
// tick and a note-off pops its key's newest start and emits a note; a full stack
// drops its oldest start. results may wait on the output register. a drain step
// scans keys upward (up to 2048) and emits one open note, or a drained result when
// none is left. reset and the begin action run a pass over the per-key depth table
// (2048 entries), during which no request is taken.
module midi_track_note_pairing_parser
  import mtnp_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input logic        clk,
  input logic        rst,
  mtnp_in_if.sink    track,
  mtnp_out_if.source result
);

  mtnp_cmd_t cmd;
  mtnp_sts_t sts;

  mtnp_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  mtnp_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .track  (track),
    .result (result)
  );

endmodule

@@ hw/rtl/mtnp_ctrl.sv @@
`timescale 1ns / 1ps
module mtnp_ctrl
  import mtnp_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  mtnp_sts_t sts,
  output mtnp_cmd_t cmd
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DEC    = 5'd2;
  localparam logic [4:0] S_OP     = 5'd3;
  localparam logic [4:0] S_OPCHK  = 5'd4;
  localparam logic [4:0] S_POPRD  = 5'd5;
  localparam logic [4:0] S_POPEM  = 5'd6;
  localparam logic [4:0] S_TICKWR = 5'd7;
  localparam logic [4:0] S_SHRD   = 5'd8;
  localparam logic [4:0] S_SHWR   = 5'd9;
  localparam logic [4:0] S_EA     = 5'd10;
  localparam logic [4:0] S_EB     = 5'd11;
  localparam logic [4:0] S_DDEC   = 5'd12;
  localparam logic [4:0] S_DRD    = 5'd13;
  localparam logic [4:0] S_DCHK   = 5'd14;
  localparam logic [4:0] S_DSRD   = 5'd15;
  localparam logic [4:0] S_DEM    = 5'd16;
  localparam logic [4:0] S_DEND   = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // sequencing of table accesses and results
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.dep_wr  = 1'b1;
        cmd.dep_val = DV_ZERO;
        cmd.wk_inc  = 1'b1;
        if (sts.wk_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.accept) state_next = S_DEC;
      end
      S_DEC: begin
        case (sts.act)
          ACT_BEGIN: begin
            cmd.clr_regs = 1'b1;
            state_next   = S_CLR;
          end
          ACT_DRAIN: state_next = S_DDEC;
          ACT_BYTE: begin
            if (sts.ph_done) begin
              state_next = S_IDLE;
            end else begin
              cmd.commit = 1'b1;
              state_next = S_OP;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_OP: begin
        if (sts.op == OP_NONE) begin
          state_next = S_EA;
        end else begin
          cmd.dep_rd = 1'b1;
          state_next = S_OPCHK;
        end
      end
      S_OPCHK: begin
        if (sts.op == OP_POP) begin
          if (sts.dr_zero) begin
            state_next = S_EA;
          end else begin
            cmd.wi_top  = 1'b1;
            cmd.dep_wr  = 1'b1;
            cmd.dep_val = DV_DEC;
            state_next  = S_POPRD;
          end
        end else if (!sts.dr_full) begin
          cmd.wi_dr   = 1'b1;
          cmd.dep_wr  = 1'b1;
          cmd.dep_val = DV_INC;
          state_next  = S_TICKWR;
        end else begin
          cmd.ovf_set = 1'b1;
          cmd.wi_one  = 1'b1;
          state_next  = (STACK_DEPTH == 1) ? S_TICKWR : S_SHRD;
        end
      end
      S_POPRD: begin
        cmd.st_rd  = 1'b1;
        state_next = S_POPEM;
      end
      S_POPEM: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = ES_NOTE;
          state_next   = S_EA;
        end
      end
      S_TICKWR: begin
        cmd.st_wr  = 1'b1;
        state_next = S_EA;
      end
      // move the kept starts down by one
      S_SHRD: begin
        cmd.st_rd  = 1'b1;
        state_next = S_SHWR;
      end
      S_SHWR: begin
        cmd.st_wr    = 1'b1;
        cmd.st_shift = 1'b1;
        if (sts.wi_end) begin
          state_next = S_TICKWR;
        end else begin
          cmd.wi_inc = 1'b1;
          state_next = S_SHRD;
        end
      end
      S_EA: begin
        if (!sts.sa_v) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = ES_SLOT_A;
          state_next   = S_EB;
        end
      end
      S_EB: begin
        if (!sts.sb_v) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = ES_SLOT_B;
          state_next   = S_IDLE;
        end
      end
      // drain: scan keys upward for an open note
      S_DDEC: begin
        cmd.wk_drain = 1'b1;
        state_next   = S_DRD;
      end
      S_DRD: begin
        cmd.dep_rd = 1'b1;
        state_next = S_DCHK;
      end
      S_DCHK: begin
        if (!sts.dr_zero) begin
          cmd.drain_pick = 1'b1;
          state_next     = S_DSRD;
        end else if (sts.wk_last) begin
          state_next = S_DEND;
        end else begin
          cmd.wk_inc    = 1'b1;
          cmd.dsub_zero = 1'b1;
          state_next    = S_DRD;
        end
      end
      S_DSRD: begin
        cmd.st_rd  = 1'b1;
        state_next = S_DEM;
      end
      S_DEM: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = ES_NOTE;
          state_next   = S_IDLE;
        end
      end
      S_DEND: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_src    = ES_DRAINED;
          cmd.drain_reset = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/mtnp_dp.sv @@
`timescale 1ns / 1ps
module mtnp_dp
  import mtnp_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  mtnp_cmd_t  cmd,
  output mtnp_sts_t  sts,
  mtnp_in_if.sink    track,
  mtnp_out_if.source result
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SW = KEY_W + IW;
  localparam logic [DW-1:0] SD_D    = DW'(STACK_DEPTH);
  localparam logic [IW-1:0] SD_LAST = IW'(STACK_DEPTH - 1);
  localparam logic [IW-1:0] WI_ONE  = IW'((STACK_DEPTH > 1) ? 1 : 0);

  // latched request
  logic [1:0] act;
  logic [7:0] b;
  logic       last;

  // parser state
  logic [31:0] tick, tick_next;
  logic [7:0]  rs, rs_next;
  logic [3:0]  ph, ph_next;
  logic [31:0] vacc, vacc_next;
  logic [2:0]  vcnt, vcnt_next;
  logic [7:0]  evs, evs_next;
  logic [7:0]  fd, fd_next;
  logic [7:0]  mk, mk_next;
  logic [31:0] brem, brem_next;
  logic [1:0]  pidx, pidx_next;
  logic [23:0] pcap, pcap_next;
  logic [1:0]  op, op_next;
  logic [KEY_W-1:0] key_next;
  logic        sa_v, sb_v;
  logic [2:0]  sa_k, sb_k;
  logic [7:0]  sl;
  logic        fin;
  logic [7:0]  fin_mk;
  logic [7:0]  mk_v;
  logic [31:0] acc_f;
  logic [2:0]  cnt_f;

  // table access
  logic [KEY_W-1:0] wk;
  logic [IW-1:0]    wi;
  logic [DW-1:0]    dr;
  logic [31:0]      sr;
  logic [DW-1:0]    dkey_sub;
  logic [KEY_W-1:0] dkey;
  logic             ovf;
  logic [DW-1:0]    sub_eff, nsub, dval;
  logic [IW-1:0]    didx;
  logic             dep_we;
  logic [DW-1:0]    depth_mem [NUM_KEYS];
  logic [31:0]      start_mem [NUM_KEYS * (2 ** IW)];

  // result slot list: {count, first kind, second kind}
  function automatic logic [7:0] add_kind(input logic [7:0] s, input logic [2:0] k);
    logic [7:0] r;
    r = s;
    if (s[7:6] == 2'd0) begin
      r = {2'd1, k, s[2:0]};
    end else if (s[7:6] == 2'd1) begin
      r = {2'd2, s[5:3], k};
    end
    return r;
  endfunction

  function automatic logic one_data(input logic [7:0] st);
    return (st[7:4] == 4'hC) || (st[7:4] == 4'hD) || (st[7:4] == 4'hF);
  endfunction

  assign track.ready = cmd.take;

  always_ff @(posedge clk) begin
    if (track.valid && cmd.take) begin
      act  <= track.action;
      b    <= track.data_byte;
      last <= track.last_byte;
    end
  end

  // one parser step for the latched byte
  always_comb begin
    tick_next = tick;
    rs_next   = rs;
    ph_next   = ph;
    vacc_next = vacc;
    vcnt_next = vcnt;
    evs_next  = evs;
    fd_next   = fd;
    mk_next   = mk;
    brem_next = brem;
    pidx_next = pidx;
    pcap_next = pcap;
    op_next   = OP_NONE;
    key_next  = {evs[3:0], fd[6:0]};
    sl        = '0;
    fin       = 1'b0;
    fin_mk    = mk;
    mk_v      = mk;
    acc_f     = {vacc[24:0], b[6:0]};
    cnt_f     = vcnt + 3'd1;
    case (ph)
      PH_DELTA: begin
        if (!b[7]) begin
          tick_next = tick + acc_f;
          vacc_next = '0;
          vcnt_next = '0;
          ph_next   = PH_STATUS;
        end else begin
          vacc_next = acc_f;
          vcnt_next = cnt_f;
          if (cnt_f >= 3'd5) begin
            sl      = add_kind(sl, K_VLERR);
            sl      = add_kind(sl, K_END);
            ph_next = PH_DONE;
          end
        end
      end
      PH_STATUS: begin
        if (!b[7]) begin
          if (rs == 8'd0) begin
            sl      = add_kind(sl, K_END);
            ph_next = PH_DONE;
          end else begin
            evs_next = rs;
            fd_next  = b;
            ph_next  = one_data(rs) ? PH_DELTA : PH_DATA2;
          end
        end else if (b == ST_META) begin
          rs_next = '0;
          ph_next = PH_META_TYPE;
        end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
          rs_next   = '0;
          vacc_next = '0;
          vcnt_next = '0;
          ph_next   = PH_SYSEX_LEN;
        end else begin
          rs_next  = b;
          evs_next = b;
          ph_next  = PH_DATA1;
        end
      end
      PH_DATA1: begin
        fd_next = b;
        ph_next = one_data(evs) ? PH_DELTA : PH_DATA2;
      end
      PH_DATA2: begin
        ph_next = PH_DELTA;
        if (evs[7:4] == 4'h9 && b != 8'd0) begin
          op_next = OP_PUSH;
        end else if (evs[7:4] == 4'h9 || evs[7:4] == 4'h8) begin
          op_next = OP_POP;
        end
      end
      PH_META_TYPE: begin
        mk_next   = b;
        vacc_next = '0;
        vcnt_next = '0;
        ph_next   = PH_META_LEN;
      end
      PH_META_LEN, PH_SYSEX_LEN: begin
        if (b[7]) begin
          vacc_next = acc_f;
          vcnt_next = cnt_f;
          if (cnt_f >= 3'd5) begin
            sl      = add_kind(sl, K_VLERR);
            sl      = add_kind(sl, K_END);
            ph_next = PH_DONE;
          end
        end else begin
          brem_next = acc_f;
          vacc_next = '0;
          vcnt_next = '0;
          if (ph == PH_SYSEX_LEN) begin
            ph_next = (acc_f == 32'd0) ? PH_DELTA : PH_SKIP;
          end else begin
            if (mk == META_TEMPO && acc_f != 32'd3) mk_v = '0;
            if (mk == META_SIG && acc_f < 32'd4) mk_v = '0;
            mk_next   = mk_v;
            pidx_next = '0;
            pcap_next = '0;
            if (acc_f == 32'd0) begin
              fin    = 1'b1;
              fin_mk = mk_v;
            end else begin
              ph_next = PH_META_DATA;
            end
          end
        end
      end
      PH_META_DATA: begin
        if (pidx != 2'd3) begin
          pcap_next = {pcap[15:0], b};
          pidx_next = pidx + 2'd1;
        end
        brem_next = brem - 32'd1;
        if (brem_next == 32'd0) fin = 1'b1;
      end
      PH_SKIP: begin
        brem_next = brem - 32'd1;
        if (brem_next == 32'd0) ph_next = PH_DELTA;
      end
      default: ;
    endcase
    // end of a meta event
    if (fin) begin
      ph_next = PH_DELTA;
      if (fin_mk == META_EOT) begin
        sl      = add_kind(sl, K_END);
        ph_next = PH_DONE;
      end else if (fin_mk == META_TEMPO) begin
        sl = add_kind(sl, K_TEMPO);
      end else if (fin_mk == META_SIG) begin
        sl = add_kind(sl, K_SIG);
      end
    end
    // chunk end
    if (last && ph_next != PH_DONE) begin
      if ((ph_next == PH_DELTA && vcnt_next != 3'd0) || ph_next == PH_META_LEN ||
          ph_next == PH_SYSEX_LEN) begin
        sl = add_kind(sl, K_VLERR);
      end
      sl      = add_kind(sl, K_END);
      ph_next = PH_DONE;
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_regs) begin
      tick <= '0;
      rs   <= '0;
      ph   <= PH_DELTA;
      vacc <= '0;
      vcnt <= '0;
      evs  <= '0;
      fd   <= '0;
      mk   <= '0;
      brem <= '0;
      pidx <= '0;
      pcap <= '0;
      op   <= OP_NONE;
      sa_v <= 1'b0;
      sb_v <= 1'b0;
    end else if (cmd.commit) begin
      tick <= tick_next;
      rs   <= rs_next;
      ph   <= ph_next;
      vacc <= vacc_next;
      vcnt <= vcnt_next;
      evs  <= evs_next;
      fd   <= fd_next;
      mk   <= mk_next;
      brem <= brem_next;
      pidx <= pidx_next;
      pcap <= pcap_next;
      op   <= op_next;
      sa_v <= (sl[7:6] != 2'd0);
      sb_v <= (sl[7:6] == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      sa_k <= sl[5:3];
      sb_k <= sl[2:0];
    end
  end

  // drain pick
  always_comb begin
    sub_eff = (dkey_sub >= dr) ? '0 : dkey_sub;
    didx    = (sub_eff == '0) ? IW'(dr - DW'(1)) : IW'(sub_eff - DW'(1));
    nsub    = sub_eff + DW'(1);
  end

  // key and slot pointers
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_regs) begin
      wk       <= '0;
      dkey     <= '0;
      dkey_sub <= '0;
      ovf      <= 1'b0;
    end else begin
      if (cmd.commit) wk <= key_next;
      else if (cmd.wk_drain) wk <= dkey;
      else if (cmd.wk_inc) wk <= wk + KEY_W'(1);
      if (cmd.ovf_set) ovf <= 1'b1;
      if (cmd.dsub_zero || cmd.drain_reset) dkey_sub <= '0;
      if (cmd.drain_reset) dkey <= '0;
      if (cmd.drain_pick) begin
        if (nsub >= dr) begin
          dkey_sub <= '0;
          dkey     <= wk + KEY_W'(1);
        end else begin
          dkey_sub <= nsub;
          dkey     <= wk;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wi_top) wi <= IW'(dr - DW'(1));
    else if (cmd.wi_dr) wi <= IW'(dr);
    else if (cmd.wi_one) wi <= WI_ONE;
    else if (cmd.wi_inc) wi <= wi + IW'(1);
    else if (cmd.drain_pick) wi <= didx;
  end

  // per-key depth table
  always_comb begin
    dep_we = cmd.dep_wr || (cmd.drain_pick && nsub >= dr);
    case (cmd.dep_val)
      DV_INC:  dval = dr + DW'(1);
      DV_DEC:  dval = dr - DW'(1);
      default: dval = '0;
    endcase
    if (cmd.drain_pick) dval = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.dep_rd) dr <= depth_mem[wk];
    if (dep_we) depth_mem[wk] <= dval;
  end

  // start tick store
  always_ff @(posedge clk) begin
    if (cmd.st_rd) sr <= start_mem[SW'({wk, wi})];
    if (cmd.st_wr) begin
      if (cmd.st_shift) start_mem[SW'({wk, wi - IW'(1)})] <= sr;
      else start_mem[SW'({wk, wi})] <= tick;
    end
  end

  // result register
  logic [2:0] ek;

  always_comb begin
    case (cmd.emit_src)
      ES_NOTE:   ek = K_NOTE;
      ES_SLOT_A: ek = sa_k;
      ES_SLOT_B: ek = sb_k;
      default:   ek = K_DRAINED;
    endcase
  end

  assign sts.out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.kind             <= ek;
      result.onset_tick       <= (ek == K_NOTE) ? sr :
                                 (ek == K_TEMPO || ek == K_SIG) ? tick : 32'd0;
      result.release_tick     <= (ek == K_TEMPO || ek == K_SIG) ? 32'd0 : tick;
      result.pitch            <= (ek == K_NOTE) ? wk[6:0] : 7'd0;
      result.channel          <= (ek == K_NOTE) ? ({1'b0, wk[10:7]} + 5'd1) : 5'd0;
      result.usec_per_quarter <= (ek == K_TEMPO) ? pcap : 24'd0;
      result.numerator        <= (ek == K_SIG) ? pcap[23:16] : 8'd0;
      result.denominator_log2 <= (ek == K_SIG) ? pcap[15:8] : 8'd0;
      result.stack_overflow   <= ovf;
    end
  end

  // status to the controller
  assign sts.accept  = track.valid && cmd.take;
  assign sts.act     = act;
  assign sts.ph_done = (ph == PH_DONE);
  assign sts.op      = op;
  assign sts.dr_zero = (dr == '0);
  assign sts.dr_full = (dr >= SD_D);
  assign sts.wk_last = (wk == '1);
  assign sts.wi_end  = (wi == SD_LAST);
  assign sts.sa_v    = sa_v;
  assign sts.sb_v    = sb_v;

endmodule
